FILE: hw/rtl/dmsc_pkg.sv
// Shared types, codes and helpers for the two-wheel step control core.
// No dependencies; imported by every module of the block.
package dmsc_pkg;

	// Command codes
	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_MOVE    = 3'd1;
	localparam logic [2:0] OP_TURN    = 3'd2;
	localparam logic [2:0] OP_FWD     = 3'd3;
	localparam logic [2:0] OP_REV     = 3'd4;
	localparam logic [2:0] OP_LEFT    = 3'd5;
	localparam logic [2:0] OP_RIGHT   = 3'd6;
	localparam logic [2:0] OP_STOP    = 3'd7;

	// Motor drive codes
	localparam logic [1:0] DRV_STOP   = 2'd0;
	localparam logic [1:0] DRV_FWD    = 2'd1;
	localparam logic [1:0] DRV_REV    = 2'd2;

	// Register indexes on the APB port
	localparam logic [1:0] REG_STEP_DUTY  = 2'd0;
	localparam logic [1:0] REG_CLICKS_DEG = 2'd1;
	localparam logic [1:0] REG_LEFT_GAIN  = 2'd2;
	localparam logic [1:0] REG_RIGHT_GAIN = 2'd3;

	// Register reset values
	localparam logic [7:0] STEP_DUTY_RST  = 8'd128;
	localparam logic [3:0] CLICKS_DEG_RST = 4'd1;
	localparam logic [8:0] GAIN_RST       = 9'd256;

	localparam int PADDR_W = 4;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	typedef struct packed {
		logic [7:0] step_duty;
		logic [3:0] clicks_deg;
		logic [8:0] left_gain;
		logic [8:0] right_gain;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        operation;
		logic signed [7:0] amount;
		logic [7:0]        speed;
		logic              left_encoder_level;
		logic              right_encoder_level;
	} item_t;

	typedef struct packed {
		logic [1:0] left_drive;
		logic [7:0] left_duty;
		logic [1:0] right_drive;
		logic [7:0] right_duty;
		logic       forward_led;
		logic       turn_led;
		logic       moving;
	} result_t;

	// Duty scaling by a Q1.8 gain: (speed * gain) >> 8, clamped to 255
	function automatic logic [7:0] scale_duty(input logic [7:0] speed, input logic [8:0] gain);
		logic [16:0] prod;
		begin
			prod = speed * gain;
			scale_duty = prod[16] ? 8'hFF : prod[15:8];
		end
	endfunction

endpackage

FILE: hw/rtl/dual_motor_encoder_step_control_core.sv
// Top level of the two-wheel step control core: input register, execution
// and result handshake. Depends on dmsc_pkg, dmsc_cfg_regs and dmsc_exec.

// Takes one command beat per clock on the s_axis side and returns one result
// beat per command on the m_axis side, in order. A command sits in the input
// register and is executed once the result beat is free or being taken; its
// result is registered and then presented as the result beat. The rate is one
// beat per cycle, limited only by m_tready. The result is the motor, LED
// and run state after the command; it is held in the state registers
// themselves, which only advance when the output beat is free or being taken.
// The user must write registers over APB only while no command is in flight; the block does not enforce it.
module dual_motor_encoder_step_control_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dmsc_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	// Command stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [2:0] operation, [10:3] amount, [18:11] speed,
	// [19] left_encoder_level, [20] right_encoder_level, [23:21] zero
	input  logic [dmsc_pkg::IN_TDATA_W-1:0] s_tdata,
	// Result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] left_drive, [9:2] left_duty, [11:10] right_drive, [19:12] right_duty,
	// [20] forward_led, [21] turn_led, [22] moving, [23] zero
	output logic [dmsc_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import dmsc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    out_valid_q;
	logic    adv;
	result_t res;

	dmsc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Execute when a command is staged and the result slot is free or draining
	assign adv      = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready & s_tvalid) begin
			item_s1.operation           <= s_tdata[2:0];
			item_s1.amount              <= s_tdata[10:3];
			item_s1.speed               <= s_tdata[18:11];
			item_s1.left_encoder_level  <= s_tdata[19];
			item_s1.right_encoder_level <= s_tdata[20];
		end
	end

	dmsc_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res.moving, res.turn_led, res.forward_led,
		res.right_duty, res.right_drive, res.left_duty, res.left_drive};

endmodule

FILE: hw/rtl/dmsc_cfg_regs.sv
// APB register file for the step control core: duty, clicks per degree, gains.
// Depends on dmsc_pkg.
module dmsc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dmsc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output dmsc_pkg::cfg_t              cfg
);
	import dmsc_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_duty         <= STEP_DUTY_RST;
			cfg_q.clicks_deg        <= CLICKS_DEG_RST;
			cfg_q.left_gain         <= GAIN_RST;
			cfg_q.right_gain        <= GAIN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_STEP_DUTY:  cfg_q.step_duty         <= pwdata[7:0];
				REG_CLICKS_DEG: cfg_q.clicks_deg        <= pwdata[3:0];
				REG_LEFT_GAIN:  cfg_q.left_gain         <= pwdata[8:0];
				REG_RIGHT_GAIN: cfg_q.right_gain        <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_STEP_DUTY:  prdata = {24'd0, cfg_q.step_duty};
			REG_CLICKS_DEG: prdata = {28'd0, cfg_q.clicks_deg};
			REG_LEFT_GAIN:  prdata = {23'd0, cfg_q.left_gain};
			REG_RIGHT_GAIN: prdata = {23'd0, cfg_q.right_gain};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/dmsc_exec.sv
// Command execution for the step control core: motor/LED/run state and
// encoder counting, updated once per beat. Depends on dmsc_pkg.
module dmsc_exec (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  dmsc_pkg::item_t   item,
	input  dmsc_pkg::cfg_t    cfg,
	output dmsc_pkg::result_t res
);
	import dmsc_pkg::*;

	typedef struct packed {
		logic [7:0] left_count;
		logic [7:0] right_count;
		logic [7:0] step_target;
		logic       left_lock;
		logic       right_lock;
		logic [1:0] left_dir;
		logic [1:0] right_dir;
		logic [7:0] left_duty;
		logic [7:0] right_duty;
		logic       led_fwd;
		logic       led_turn;
		logic       counted_run;
	} state_t;

	state_t      st_q;
	state_t      st_n;
	logic [7:0]  mag;
	logic        back;
	logic [11:0] turn_prod;
	logic [7:0]  turn_steps;
	logic        do_check;
	logic        pivot;

	// Magnitude of the signed amount; -128 gives 128
	assign mag        = item.amount[7] ? (8'd0 - item.amount) : item.amount;
	assign back       = item.amount[7] | (item.amount == 8'sd0);
	assign turn_prod  = mag * cfg.clicks_deg;
	assign turn_steps = (turn_prod[11:8] != 4'd0) ? 8'hFF : turn_prod[7:0];
	assign pivot      = (item.operation == OP_TURN);

	// Next state for one command
	always_comb begin
		st_n     = st_q;
		do_check = 1'b0;
		case (item.operation)
			OP_TICK: begin
				if (st_q.counted_run) begin
					do_check = 1'b1;
					if (item.left_encoder_level) begin
						if (!st_q.left_lock) begin
							if (st_q.left_count != 8'hFF)
								st_n.left_count = st_q.left_count + 8'd1;
							st_n.left_lock = 1'b1;
						end
					end else begin
						st_n.left_lock = 1'b0;
					end
					if (item.right_encoder_level) begin
						if (!st_q.right_lock) begin
							if (st_q.right_count != 8'hFF)
								st_n.right_count = st_q.right_count + 8'd1;
							st_n.right_lock = 1'b1;
						end
					end else begin
						st_n.right_lock = 1'b0;
					end
				end
			end
			OP_MOVE, OP_TURN: begin
				do_check         = 1'b1;
				st_n.left_count  = 8'd0;
				st_n.right_count = 8'd0;
				st_n.left_lock   = 1'b0;
				st_n.right_lock  = 1'b0;
				st_n.step_target = pivot ? turn_steps : mag;
				st_n.led_fwd     = ~pivot;
				st_n.led_turn    = pivot;
				st_n.left_dir    = back ? DRV_REV : DRV_FWD;
				if (pivot)
					st_n.right_dir = back ? DRV_REV : DRV_FWD;
				else
					st_n.right_dir = back ? DRV_FWD : DRV_REV;
				st_n.left_duty   = cfg.step_duty;
				st_n.right_duty  = cfg.step_duty;
				st_n.counted_run = 1'b1;
			end
			OP_FWD, OP_REV, OP_LEFT, OP_RIGHT: begin
				st_n.counted_run = 1'b0;
				st_n.led_fwd     = (item.operation == OP_FWD) | (item.operation == OP_REV);
				st_n.led_turn    = (item.operation == OP_LEFT) | (item.operation == OP_RIGHT);
				st_n.left_dir    = ((item.operation == OP_FWD) | (item.operation == OP_RIGHT))
					? DRV_FWD : DRV_REV;
				st_n.right_dir   = ((item.operation == OP_REV) | (item.operation == OP_RIGHT))
					? DRV_FWD : DRV_REV;
				st_n.left_duty   = scale_duty(item.speed, cfg.left_gain);
				st_n.right_duty  = scale_duty(item.speed, cfg.right_gain);
			end
			default: begin
				st_n.left_dir    = DRV_STOP;
				st_n.right_dir   = DRV_STOP;
				st_n.left_duty   = 8'd0;
				st_n.right_duty  = 8'd0;
				st_n.led_fwd     = 1'b0;
				st_n.led_turn    = 1'b0;
				st_n.counted_run = 1'b0;
			end
		endcase

		// Stop each wheel at target; run ends when both are done
		if (do_check) begin
			if (st_n.left_count >= st_n.step_target) begin
				st_n.left_dir  = DRV_STOP;
				st_n.left_duty = 8'd0;
			end
			if (st_n.right_count >= st_n.step_target) begin
				st_n.right_dir  = DRV_STOP;
				st_n.right_duty = 8'd0;
			end
			if ((st_n.left_count >= st_n.step_target) &&
				(st_n.right_count >= st_n.step_target))
				st_n.counted_run = 1'b0;
		end
	end

	// State doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= st_n;
		end
	end

	assign res.left_drive  = st_q.left_dir;
	assign res.left_duty   = st_q.left_duty;
	assign res.right_drive = st_q.right_dir;
	assign res.right_duty  = st_q.right_duty;
	assign res.forward_led = st_q.led_fwd;
	assign res.turn_led    = st_q.led_turn;
	assign res.moving      = st_q.counted_run;

endmodule

FILE: hw/rtl/dmsc_checker.sv
// Port-level checks for the two-wheel step control core, bound to the top.
// Depends on dmsc_pkg and dual_motor_encoder_step_control_core.
module dmsc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata
);
	import dmsc_pkg::*;

	logic [1:0] l_drv;
	logic [7:0] l_duty;
	logic [1:0] r_drv;
	logic [7:0] r_duty;
	logic       led_f;
	logic       led_t;
	logic       mov;

	assign l_drv  = m_tdata[1:0];
	assign l_duty = m_tdata[9:2];
	assign r_drv  = m_tdata[11:10];
	assign r_duty = m_tdata[19:12];
	assign led_f  = m_tdata[20];
	assign led_t  = m_tdata[21];
	assign mov    = m_tdata[22];

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// A stopped motor never carries duty
	a_stop_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (l_drv == DRV_STOP || r_drv == DRV_STOP) |->
		(l_drv != DRV_STOP || l_duty == 8'd0) && (r_drv != DRV_STOP || r_duty == 8'd0))
		else $error("stopped motor with nonzero duty");

	// The two LEDs are never lit together
	a_led_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(led_f && led_t))
		else $error("both LEDs on");

	// A counted run always shows its LED and at least one driven wheel
	a_run_led: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mov |-> (led_f || led_t) && (l_drv != DRV_STOP || r_drv != DRV_STOP))
		else $error("counted run without LED or driven wheel");

endmodule

bind dual_motor_encoder_step_control_core dmsc_checker u_dmsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
